FILE: hw/rtl/pcapp_pkg.sv
`default_nettype none
package pcapp_pkg;

    // parsing phases, one-hot
    typedef enum logic [8:0] {
        PH_MAGIC    = 9'b000000001,
        PH_PCAP_HDR = 9'b000000010,
        PH_PCAP_REC = 9'b000000100,
        PH_PAYLOAD  = 9'b000001000,
        PH_NG_SHB   = 9'b000010000,
        PH_NG_BLK   = 9'b000100000,
        PH_NG_IDB   = 9'b001000000,
        PH_NG_EPB   = 9'b010000000,
        PH_SKIP     = 9'b100000000
    } phase_t;

    typedef enum logic [1:0] {
        FMT_PCAP    = 2'd0,
        FMT_PCAP_NS = 2'd1,
        FMT_NG      = 2'd2
    } format_t;

    localparam logic [1:0] KIND_DESC    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MAGIC     = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_BLOCK_LEN = 3'd3;
    localparam logic [2:0] ST_NO_IF     = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    localparam logic [31:0] MAGIC_US      = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_US_SWAP = 32'hd4c3b2a1;
    localparam logic [31:0] MAGIC_NS      = 32'ha1b23c4d;
    localparam logic [31:0] MAGIC_NS_SWAP = 32'h4d3cb2a1;
    localparam logic [31:0] MAGIC_SHB     = 32'h0a0d0d0a;
    localparam logic [31:0] BOM_NATIVE    = 32'h1a2b3c4d;
    localparam logic [31:0] BOM_SWAP      = 32'h4d3c2b1a;
    localparam logic [31:0] BLK_IDB       = 32'h00000001;
    localparam logic [31:0] BLK_EPB       = 32'h00000006;

    localparam int REG_FILE_LEN = 0;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pcap_pcapng_record_parser_unit.sv
`default_nettype none
// Capture file parser for classic pcap and pcapng.
// Input channel s_*: one file byte per request (s_data_byte), valid/ready.
// Result channel m_*: descriptors, payload bytes and one error result.
// Configuration: APB port, file length register at byte address 0 (64-bit
// data, low 48 bits used); write it while the block is idle.
// Each byte is parsed in the cycle it is accepted; any result it causes
// is in the output register at the next clock edge; throughput is one
// byte per cycle as long as the receiver does not stall the results.
// The output register decouples the sides: a new byte is taken while a
// result waits, as long as the receiver takes it in the same cycle; if
// the receiver stalls, s_ready drops until the result is taken.
// Bytes beyond the configured file length give no result; after an error
// result the block swallows all bytes until reset.
// Reset (aresetn low, synchronous) returns to the magic phase with an
// empty interface table; no clearing pass is needed.
// The interface link table is read registered, addressed by the packet
// block's interface field before its last header byte; this sets no limit on rate.
module pcap_pcapng_record_parser_unit
    import pcapp_pkg::*;
#(
    parameter int MAX_INTERFACES = 16,
    parameter int POSITION_BITS  = 48
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [2:0]       m_status,
    output logic [7:0]       m_payload_byte,
    output logic             m_last_byte,
    output logic [31:0]      m_time_high,
    output logic [31:0]      m_time_low,
    output logic [31:0]      m_captured_length,
    output logic [31:0]      m_original_length,
    output logic [31:0]      m_link_layer,
    output logic             m_nanosecond_time,
    output logic [31:0]      m_interface_number
);

    localparam int PW    = POSITION_BITS;
    localparam int IDX_W = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int CNT_W = $clog2(MAX_INTERFACES + 1);

    // state
    logic [47:0]      fsz_reg;
    phase_t           phase_reg, phase_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [4:0]       fb_reg, fb_next;
    logic [31:0]      wa_reg, wa_next;
    logic             swp_reg, swp_next;
    format_t          fmt_reg, fmt_next;
    logic [PW-1:0]    bend_reg, bend_next;
    logic [31:0]      bk_reg, bk_next;
    logic [31:0]      rf_reg [5];
    logic [31:0]      rf_next [5];
    logic [31:0]      pr_reg, pr_next;
    logic [31:0]      dl_reg, dl_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             stop_reg, stop_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  o_kind;
    logic [2:0]  o_status;
    logic [7:0]  o_byte;
    logic        o_last;
    logic [31:0] o_th, o_tl, o_cap, o_orig, o_link, o_ifc;
    logic        o_ns;
    logic        emit;

    logic             tbl_we;
    logic [15:0]      tbl_wdata;
    logic [15:0]      tbl_rdata;

    logic acc, cfg_wr;

    assign pready  = 1'b1;
    assign s_ready = !m_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && (paddr == 4'(8 * REG_FILE_LEN));
    assign prdata  = (paddr == 4'(8 * REG_FILE_LEN)) ? {16'h0, fsz_reg} : 64'h0;
    assign m_valid = m_valid_reg;

    pcapp_if_table #(
        .DEPTH  (MAX_INTERFACES),
        .ADDR_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (tbl_wdata),
        .rd_addr (rf_reg[0][IDX_W-1:0]),
        .rd_data (tbl_rdata)
    );

    // parse one byte
    always_comb begin
        logic [63:0] fsz64, here64, rem, end64, after64;
        logic [PW-1:0] after;
        logic [4:0]  fb;
        logic [1:0]  k;
        logic [31:0] w, fw, len, minlen;
        logic [15:0] l16;
        logic        err;
        logic [2:0]  ecode;
        logic        desc;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        fb_next    = fb_reg;
        wa_next    = wa_reg;
        swp_next   = swp_reg;
        fmt_next   = fmt_reg;
        bend_next  = bend_reg;
        bk_next    = bk_reg;
        for (int i = 0; i < 5; i++) rf_next[i] = rf_reg[i];
        pr_next    = pr_reg;
        dl_next    = dl_reg;
        cnt_next   = cnt_reg;
        stop_next  = stop_reg;
        tbl_we     = 1'b0;
        tbl_wdata  = 16'h0;
        emit       = 1'b0;
        o_kind     = KIND_DESC;
        o_status   = ST_OK;
        o_byte     = 8'h0;
        o_last     = 1'b0;
        o_th       = 32'h0;
        o_tl       = 32'h0;
        o_cap      = 32'h0;
        o_orig     = 32'h0;
        o_link     = 32'h0;
        o_ns       = 1'b0;
        o_ifc      = 32'h0;
        err        = 1'b0;
        ecode      = ST_OK;
        desc       = 1'b0;
        fsz64      = {16'h0, fsz_reg};
        here64     = 64'(pos_reg);
        rem        = fsz64 - here64;
        after      = pos_reg + PW'(1);
        after64    = 64'(after);
        fb         = fb_reg;
        k          = fb_reg[1:0];
        w          = (k == 2'd0) ? 32'(s_data_byte)
                                 : (wa_reg | (32'(s_data_byte) << {k, 3'b000}));
        fw         = swp_reg ? swap32(w) : w;
        len        = 32'h0;
        minlen     = 32'h0;
        l16        = 16'h0;
        end64      = 64'h0;

        if (acc && !stop_reg && (here64 < fsz64)) begin
            pos_next = after;
            wa_next  = w;
            unique case (phase_reg)
                PH_MAGIC: begin
                    if (fb == 5'd0 && fsz64 < 64'd4) begin
                        err = 1'b1; ecode = ST_SHORT;
                    end else if (fb < 5'd3) begin
                        fb_next = fb + 5'd1;
                    end else if (w == MAGIC_US || w == MAGIC_US_SWAP ||
                                 w == MAGIC_NS || w == MAGIC_NS_SWAP) begin
                        if (fsz64 < 64'd24) begin
                            err = 1'b1; ecode = ST_SHORT;
                        end else begin
                            fmt_next = (w == MAGIC_US || w == MAGIC_US_SWAP)
                                       ? FMT_PCAP : FMT_PCAP_NS;
                            swp_next = (w == MAGIC_US_SWAP || w == MAGIC_NS_SWAP);
                            phase_next = PH_PCAP_HDR;
                            fb_next = 5'd4;
                        end
                    end else if (w == MAGIC_SHB) begin
                        if (fsz64 < 64'd12) begin
                            err = 1'b1; ecode = ST_SHORT;
                        end else begin
                            fmt_next = FMT_NG;
                            phase_next = PH_NG_SHB;
                            fb_next = 5'd4;
                        end
                    end else begin
                        err = 1'b1; ecode = ST_MAGIC;
                    end
                end
                PH_PCAP_HDR: begin
                    if (fb < 5'd23) begin
                        fb_next = fb + 5'd1;
                    end else begin
                        dl_next = fw;
                        phase_next = PH_PCAP_REC;
                        fb_next = 5'd0;
                    end
                end
                PH_PCAP_REC: begin
                    if (fb == 5'd0 && rem < 64'd16) begin
                        err = 1'b1; ecode = ST_TRUNC;
                    end else begin
                        if (k == 2'd3) rf_next[fb[3:2]] = fw;
                        if (fb < 5'd15) begin
                            fb_next = fb + 5'd1;
                        end else begin
                            fb_next = 5'd0;
                            if (64'(rf_next[2]) > rem - 64'd1) begin
                                err = 1'b1; ecode = ST_TRUNC;
                            end else begin
                                phase_next = (rf_next[2] != 32'h0) ? PH_PAYLOAD
                                                                   : PH_PCAP_REC;
                                desc   = 1'b1;
                                o_th   = rf_next[0];
                                o_tl   = rf_next[1];
                                o_cap  = rf_next[2];
                                o_orig = rf_next[3];
                                o_link = dl_reg;
                                o_ns   = (fmt_reg == FMT_PCAP_NS);
                                o_ifc  = 32'h0;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    emit    = 1'b1;
                    o_kind  = KIND_PAYLOAD;
                    o_byte  = s_data_byte;
                    pr_next = pr_reg - 32'd1;
                    o_last  = (pr_next == 32'h0);
                    if (pr_next == 32'h0) begin
                        phase_next = (fmt_reg == FMT_NG) ? PH_SKIP : PH_PCAP_REC;
                        fb_next = 5'd0;
                    end
                end
                PH_NG_SHB: begin
                    if (fb == 5'd7) bk_next = w;
                    if (fb < 5'd11) begin
                        fb_next = fb + 5'd1;
                    end else if (w != BOM_NATIVE && w != BOM_SWAP) begin
                        err = 1'b1; ecode = ST_MAGIC;
                    end else begin
                        swp_next = (w == BOM_SWAP);
                        len = swp_next ? swap32(bk_reg) : bk_reg;
                        bk_next = MAGIC_SHB;
                        if (len < 32'd12) begin
                            err = 1'b1; ecode = ST_BLOCK_LEN;
                        end else if (64'(len) > fsz64) begin
                            err = 1'b1; ecode = ST_TRUNC;
                        end else begin
                            bend_next = PW'(64'(len));
                            fb_next = 5'd0;
                            if (after == bend_next) begin
                                phase_next = PH_NG_BLK;
                                if (cnt_reg == '0 && after64 >= fsz64) begin
                                    err = 1'b1; ecode = ST_NO_IF;
                                end
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_NG_BLK: begin
                    if (fb == 5'd0 && rem < 64'd12) begin
                        err = 1'b1;
                        ecode = (cnt_reg == '0) ? ST_NO_IF : ST_TRUNC;
                    end else if (fb == 5'd3 && fw != BLK_IDB && cnt_reg == '0) begin
                        bk_next = fw;
                        err = 1'b1; ecode = ST_NO_IF;
                    end else begin
                        if (fb == 5'd3) bk_next = fw;
                        if (fb < 5'd7) begin
                            fb_next = fb + 5'd1;
                        end else begin
                            len = fw;
                            minlen = (bk_reg == BLK_IDB) ? 32'd20 :
                                     (bk_reg == BLK_EPB) ? 32'd32 : 32'd12;
                            end64 = here64 - 64'd7 + 64'(len);
                            if (len < minlen) begin
                                err = 1'b1; ecode = ST_BLOCK_LEN;
                            end else if (end64 > fsz64) begin
                                err = 1'b1; ecode = ST_TRUNC;
                            end else begin
                                bend_next = PW'(end64);
                                fb_next = 5'd8;
                                phase_next = (bk_reg == BLK_IDB) ? PH_NG_IDB :
                                             (bk_reg == BLK_EPB) ? PH_NG_EPB : PH_SKIP;
                            end
                        end
                    end
                end
                PH_NG_IDB: begin
                    if (fb < 5'd11) begin
                        fb_next = fb + 5'd1;
                    end else begin
                        l16 = swp_reg ? fw[31:16] : w[15:0];
                        if (cnt_reg < CNT_W'(MAX_INTERFACES)) begin
                            tbl_we    = 1'b1;
                            tbl_wdata = l16;
                            if (cnt_reg == '0) dl_next = 32'(l16);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        fb_next = 5'd0;
                        phase_next = PH_SKIP;
                    end
                end
                PH_NG_EPB: begin
                    if (k == 2'd3) rf_next[3'((fb - 5'd8) >> 2)] = fw;
                    if (fb < 5'd27) begin
                        fb_next = fb + 5'd1;
                    end else begin
                        fb_next = 5'd0;
                        phase_next = PH_SKIP;
                        if (!(64'(rf_next[3]) + 64'd4 > 64'(bend_reg) - after64)) begin
                            if (rf_next[3] != 32'h0) phase_next = PH_PAYLOAD;
                            desc   = 1'b1;
                            o_th   = rf_next[1];
                            o_tl   = rf_next[2];
                            o_cap  = rf_next[3];
                            o_orig = rf_next[4];
                            o_link = (rf_next[0] < 32'(cnt_reg)) ? 32'(tbl_rdata) : dl_reg;
                            o_ns   = 1'b0;
                            o_ifc  = rf_next[0];
                        end
                    end
                end
                PH_SKIP: begin
                    fb_next = 5'd0;
                    if (after == bend_reg) begin
                        phase_next = PH_NG_BLK;
                        if (cnt_reg == '0 && after64 >= fsz64) begin
                            err = 1'b1; ecode = ST_NO_IF;
                        end
                    end
                end
                default: begin
                    err = 1'b1; ecode = ST_MAGIC;
                end
            endcase

            // load the descriptor or the error into the result
            if (desc) begin
                emit    = 1'b1;
                pr_next = o_cap;
            end
            if (err) begin
                stop_next = 1'b1;
                emit      = 1'b1;
                o_kind    = KIND_ERROR;
                o_status  = ecode;
                o_byte    = 8'h0;
                o_last    = 1'b0;
            end
        end
    end

    // hold a result until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (emit) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsz_reg     <= '0;
            phase_reg   <= PH_MAGIC;
            pos_reg     <= '0;
            fb_reg      <= '0;
            wa_reg      <= '0;
            swp_reg     <= 1'b0;
            fmt_reg     <= FMT_PCAP;
            bend_reg    <= '0;
            bk_reg      <= '0;
            pr_reg      <= '0;
            dl_reg      <= '0;
            cnt_reg     <= '0;
            stop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++) rf_reg[i] <= '0;
        end else begin
            if (cfg_wr) fsz_reg <= pwdata[47:0];
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            fb_reg      <= fb_next;
            wa_reg      <= wa_next;
            swp_reg     <= swp_next;
            fmt_reg     <= fmt_next;
            bend_reg    <= bend_next;
            bk_reg      <= bk_next;
            pr_reg      <= pr_next;
            dl_reg      <= dl_next;
            cnt_reg     <= cnt_next;
            stop_reg    <= stop_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 5; i++) rf_reg[i] <= rf_next[i];
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind             <= o_kind;
            m_status           <= o_status;
            m_payload_byte     <= o_byte;
            m_last_byte        <= o_last;
            m_time_high        <= o_th;
            m_time_low         <= o_tl;
            m_captured_length  <= o_cap;
            m_original_length  <= o_orig;
            m_link_layer       <= o_link;
            m_nanosecond_time  <= o_ns;
            m_interface_number <= o_ifc;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pcapp_if_table.sv
`default_nettype none
module pcapp_if_table
    import pcapp_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [15:0]       wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]            rd_data
);

    logic [15:0] mem [DEPTH];

    // write one link type, read one back registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire
